// ===== src/escape_sequence_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Escape sequence decoder assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define ESD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ESD_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Shared result types and result queue sizing.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
   } result_type;

   // Results produced by one character: a count of zero to two and the slots.
   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } decode_out_type;

endpackage

// ===== src/esd_decode.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder core
// Holds the escape state and decodes one character into up to two results.
// ----------------------------------------------------------------------------
module esd_decode
   import esd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     in_char,
   input  logic           in_last,
   output decode_out_type dec
);

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_ESC,
      MODE_HEX,
      MODE_OCT
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] HEX_TEN   = 8'd10;

   // Returns a hit flag above the control byte for a lettered escape.
   function automatic logic [8:0] control_code(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      unique case (c)
         8'h61:   r = {1'b1, 8'd7};
         8'h62:   r = {1'b1, 8'd8};
         8'h66:   r = {1'b1, 8'd12};
         8'h72:   r = {1'b1, 8'd13};
         8'h6E:   r = {1'b1, 8'd10};
         8'h74:   r = {1'b1, 8'd9};
         8'h76:   r = {1'b1, 8'd11};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Returns a hit flag above the digit value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      priority if (c >= CH_0 && c <= CH_9) begin
         r = {1'b1, 4'(c - CH_0)};
      end else if (c >= CH_LA && c <= CH_LF) begin
         r = {1'b1, 4'(c - CH_LA + HEX_TEN)};
      end else if (c >= CH_UA && c <= CH_UF) begin
         r = {1'b1, 4'(c - CH_UA + HEX_TEN)};
      end else begin
         r = '0;
      end
      return r;
   endfunction

   mode_type   mode_ff, mode_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] acc_ff, acc_in;

   logic [1:0] n;
   logic [7:0] slot_byte [2];
   logic       slot_vld  [2];
   logic       slot_eos  [2];
   logic       do_text;
   logic [8:0] ctrl;
   logic [4:0] hex;
   logic       is_oct;
   logic       is_letter;
   logic [1:0] cnt_next;
   logic [7:0] acc_next;

   assign ctrl      = control_code(in_char);
   assign hex       = hex_digit(in_char);
   assign is_oct    = (in_char >= CH_0) && (in_char <= CH_7);
   assign is_letter = ((in_char >= CH_LA) && (in_char <= CH_LZ))
                   || ((in_char >= CH_UA) && (in_char <= CH_UZ));

   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      n            = 2'd0;
      slot_byte[0] = '0;
      slot_byte[1] = '0;
      slot_vld[0]  = 1'b0;
      slot_vld[1]  = 1'b0;
      slot_eos[0]  = 1'b0;
      slot_eos[1]  = 1'b0;
      do_text      = 1'b0;
      cnt_next     = cnt_ff + 2'd1;
      acc_next     = '0;

      unique case (mode_ff)
         MODE_TEXT: begin
            do_text = 1'b1;
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            priority if (ctrl[8]) begin
               slot_byte[n[0]] = ctrl[7:0];
               slot_vld[n[0]]  = 1'b1;
               n               = n + 2'd1;
            end else if (in_char == CH_QMARK || in_char == CH_BSLASH
                         || in_char == CH_QUOTE || in_char == CH_DQUOTE) begin
               slot_byte[n[0]] = in_char;
               slot_vld[n[0]]  = 1'b1;
               n               = n + 2'd1;
            end else if (in_char == CH_X) begin
               mode_in = MODE_HEX;
               cnt_in  = 2'd0;
               acc_in  = '0;
            end else if (is_oct) begin
               mode_in = MODE_OCT;
               cnt_in  = 2'd1;
               acc_in  = {5'd0, in_char[2:0]};
            end else if (is_letter) begin
               mode_in = MODE_TEXT;
            end else begin
               slot_byte[n[0]] = '0;
               slot_vld[n[0]]  = 1'b1;
               n               = n + 2'd1;
               do_text         = 1'b1;
            end
         end
         MODE_HEX: begin
            if (hex[4]) begin
               acc_next = {acc_ff[3:0], hex[3:0]};
               if (cnt_next >= 2'd2) begin
                  slot_byte[n[0]] = acc_next;
                  slot_vld[n[0]]  = 1'b1;
                  n               = n + 2'd1;
                  mode_in         = MODE_TEXT;
                  cnt_in          = 2'd0;
                  acc_in          = '0;
               end else begin
                  cnt_in = cnt_next;
                  acc_in = acc_next;
               end
            end else begin
               slot_byte[n[0]] = acc_ff;
               slot_vld[n[0]]  = 1'b1;
               n               = n + 2'd1;
               cnt_in          = 2'd0;
               acc_in          = '0;
               do_text         = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               acc_next = {acc_ff[4:0], in_char[2:0]};
               if (cnt_next == 2'd3 || cnt_next == 2'd0) begin
                  slot_byte[n[0]] = acc_next;
                  slot_vld[n[0]]  = 1'b1;
                  n               = n + 2'd1;
                  mode_in         = MODE_TEXT;
                  cnt_in          = 2'd0;
                  acc_in          = '0;
               end else begin
                  cnt_in = cnt_next;
                  acc_in = acc_next;
               end
            end else begin
               slot_byte[n[0]] = acc_ff;
               slot_vld[n[0]]  = 1'b1;
               n               = n + 2'd1;
               cnt_in          = 2'd0;
               acc_in          = '0;
               do_text         = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_TEXT;
         end
      endcase

      if (do_text) begin
         if (in_char == CH_BSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            mode_in         = MODE_TEXT;
            slot_byte[n[0]] = in_char;
            slot_vld[n[0]]  = 1'b1;
            n               = n + 2'd1;
         end
      end

      if (in_last) begin
         priority if (mode_in == MODE_ESC) begin
            slot_byte[n[0]] = '0;
            slot_vld[n[0]]  = 1'b1;
            n               = n + 2'd1;
         end else if (mode_in == MODE_HEX || mode_in == MODE_OCT) begin
            slot_byte[n[0]] = acc_in;
            slot_vld[n[0]]  = 1'b1;
            n               = n + 2'd1;
         end else begin
            mode_in = MODE_TEXT;
         end
         // A string that yields no byte still gets one result to close it.
         if (n == 2'd0) begin
            slot_byte[0] = '0;
            slot_vld[0]  = 1'b0;
            n            = 2'd1;
         end
         if (n == 2'd1) begin
            slot_eos[0] = 1'b1;
         end else begin
            slot_eos[1] = 1'b1;
         end
         mode_in = MODE_TEXT;
         cnt_in  = 2'd0;
         acc_in  = '0;
      end
   end

   assign dec.count               = n;
   assign dec.slot0.out_byte      = slot_byte[0];
   assign dec.slot0.byte_valid    = slot_vld[0];
   assign dec.slot0.end_of_string = slot_eos[0];
   assign dec.slot1.out_byte      = slot_byte[1];
   assign dec.slot1.byte_valid    = slot_vld[1];
   assign dec.slot1.end_of_string = slot_eos[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         cnt_ff  <= 2'd0;
         acc_ff  <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

// ===== src/esd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder result queue
// Takes up to two result words a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module esd_result_fifo
   import esd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  decode_out_type        dec,
   output logic [FIFO_LVL_W-1:0] space,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_end_of_string
);

   result_type mem [FIFO_DEPTH];

   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;
   logic [FIFO_LVL_W-1:0] push_n;
   logic                  pop;
   result_type            head;

   assign push_n    = push ? FIFO_LVL_W'(dec.count) : '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_in = FIFO_PTR_W'(wr_ptr_ff + FIFO_PTR_W'(push_n));
   assign rd_ptr_in = pop ? FIFO_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign level_in  = level_ff + push_n - FIFO_LVL_W'(pop);
   assign space     = FIFO_LVL_W'(FIFO_DEPTH) - level_ff;

   assign head              = mem[rd_ptr_ff];
   assign rsp_valid         = (level_ff != '0);
   assign rsp_out_byte      = head.out_byte;
   assign rsp_byte_valid    = head.byte_valid;
   assign rsp_end_of_string = head.end_of_string;

   always_ff @(posedge clock) begin
      if (push && dec.count != 2'd0) begin
         mem[wr_ptr_ff] <= dec.slot0;
      end
      if (push && dec.count == 2'd2) begin
         mem[FIFO_PTR_W'(wr_ptr_ff + 1'b1)] <= dec.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// Path: a taken character is held in the input register, decoded as it leaves it and
// written into the result queue, which then offers its first result word.
// Throughput: one character per cycle; the four-word result queue absorbs the
// second word of a two-result character and stalls the input only when it lacks
// room for all the words of the waiting character.
// Reset: synchronous, active high; it returns to plain text and empties the queue.
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes C string escapes from a character stream into bytes.
// ----------------------------------------------------------------------------
`include "escape_sequence_decoder_assert.svh"

module escape_sequence_decoder
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_string
);

   logic                  in_vld_ff;
   logic [7:0]            in_char_ff;
   logic                  in_last_ff;
   logic                  advance;
   logic                  load;
   logic [FIFO_LVL_W-1:0] space;
   decode_out_type        dec;

   assign advance   = in_vld_ff && (FIFO_LVL_W'(dec.count) <= space);
   assign req_stall = in_vld_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (load) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_char_ff <= req_in_char;
         in_last_ff <= req_in_last;
      end
   end

   esd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .take    (advance),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .dec     (dec)
   );

   esd_result_fifo u_fifo (
      .clock             (clock),
      .reset             (reset),
      .push              (advance),
      .dec               (dec),
      .space             (space),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_string (rsp_end_of_string)
   );

   `ESD_ASSERT_IMP(a_last_closes, clock, reset, advance && in_last_ff, (dec.count == 2'd1) ? dec.slot0.end_of_string : dec.slot1.end_of_string, "Final character did not mark its last result word.")
   `ESD_ASSERT_IMP(a_no_early_eos, clock, reset, advance && !in_last_ff, !dec.slot0.end_of_string && !dec.slot1.end_of_string, "End of string flagged before the final character.")
   `ESD_ASSERT_NEXT(a_result_follows, clock, reset, advance && dec.count != 2'd0, rsp_valid, "Decoded result word missing from the result queue.")

endmodule

// ===== tb/sv/escape_sequence_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Feeds directed and random C string literals, character by character, into
// the decoder while both sides hold off at random, bar a last run with none.
// Every character runs through an independent decoder model predicting byte
// words; each word leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_test;
   import esd_pkg::*;

   typedef enum logic [1:0] {
      TEXT_MODE,
      ESCAPE_MODE,
      HEX_MODE,
      OCTAL_MODE
   } decode_mode_type;

   localparam logic [7:0] BACKSLASH = 8'h5c;
   localparam logic [7:0] HEX_INTRO = "x";
   localparam logic [7:0] ZERO_CHAR = "0";
   localparam logic [7:0] BELL_BYTE = 8'd7;
   localparam logic [7:0] BACKSPACE_BYTE = 8'd8;
   localparam logic [7:0] FORM_FEED_BYTE = 8'd12;
   localparam logic [7:0] RETURN_BYTE = 8'd13;
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] TAB_BYTE = 8'd9;
   localparam logic [7:0] VTAB_BYTE = 8'd11;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_string;

   int send_idle_pct = 12;
   int recv_idle_pct = 65;
   int chars_sent = 0;
   int failures = 0;
   int quiet_cycles = 0;

   decode_mode_type text_mode = TEXT_MODE;
   logic [1:0]      digit_tally = 2'd0;
   logic [7:0]      escape_value = 8'h00;
   result_type      expected_bytes[$];
   logic [7:0]      pending_text[$];

   escape_sequence_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_char       (req_in_char),
      .req_in_last       (req_in_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_string (rsp_end_of_string)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void push_byte(input logic [7:0] value, input logic valid);
      result_type word;
      word.out_byte = valid ? value : 8'h00;
      word.byte_valid = valid;
      word.end_of_string = 1'b0;
      expected_bytes.push_back(word);
   endfunction

   function automatic void decode_text(input logic [7:0] ch);
      text_mode = TEXT_MODE;
      if (ch == BACKSLASH)
         text_mode = ESCAPE_MODE;
      else
         push_byte(ch, 1'b1);
   endfunction

   function automatic int hex_digit_value(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch - "0");
      if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
      if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
      return -1;
   endfunction

   function automatic void decode_escape(input logic [7:0] ch);
      text_mode = TEXT_MODE;
      case (ch)
         "a": push_byte(BELL_BYTE, 1'b1);
         "b": push_byte(BACKSPACE_BYTE, 1'b1);
         "f": push_byte(FORM_FEED_BYTE, 1'b1);
         "r": push_byte(RETURN_BYTE, 1'b1);
         "n": push_byte(NEWLINE_BYTE, 1'b1);
         "t": push_byte(TAB_BYTE, 1'b1);
         "v": push_byte(VTAB_BYTE, 1'b1);
         "?", "\\", "'", "\"": push_byte(ch, 1'b1);
         HEX_INTRO: begin
            text_mode = HEX_MODE;
            digit_tally = 2'd0;
            escape_value = 8'h00;
         end
         default: begin
            if (ch >= "0" && ch <= "7") begin
               text_mode = OCTAL_MODE;
               digit_tally = 2'd1;
               escape_value = {5'd0, ch[2:0]};
            end else if (!((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) begin
               push_byte(8'h00, 1'b1);
               decode_text(ch);
            end
         end
      endcase
   endfunction

   function automatic void predict_char(input logic [7:0] ch, input logic last);
      int first_new;
      int digit;
      first_new = expected_bytes.size();
      case (text_mode)
         TEXT_MODE: decode_text(ch);
         ESCAPE_MODE: decode_escape(ch);
         HEX_MODE: begin
            digit = hex_digit_value(ch);
            if (digit >= 0) begin
               escape_value = {escape_value[3:0], 4'(digit)};
               digit_tally = digit_tally + 2'd1;
               if (digit_tally >= 2'd2) begin
                  push_byte(escape_value, 1'b1);
                  text_mode = TEXT_MODE;
                  digit_tally = 2'd0;
                  escape_value = 8'h00;
               end
            end else begin
               push_byte(escape_value, 1'b1);
               digit_tally = 2'd0;
               escape_value = 8'h00;
               decode_text(ch);
            end
         end
         default: begin
            if (ch >= "0" && ch <= "7") begin
               escape_value = {escape_value[4:0], ch[2:0]};
               digit_tally = digit_tally + 2'd1;
               if (digit_tally >= 2'd3 || digit_tally == 2'd0) begin
                  push_byte(escape_value, 1'b1);
                  text_mode = TEXT_MODE;
                  digit_tally = 2'd0;
                  escape_value = 8'h00;
               end
            end else begin
               push_byte(escape_value, 1'b1);
               digit_tally = 2'd0;
               escape_value = 8'h00;
               decode_text(ch);
            end
         end
      endcase
      if (last) begin
         if (text_mode == ESCAPE_MODE)
            push_byte(8'h00, 1'b1);
         else if (text_mode == HEX_MODE || text_mode == OCTAL_MODE)
            push_byte(escape_value, 1'b1);
         if (expected_bytes.size() == first_new)
            push_byte(8'h00, 1'b0);
         expected_bytes[expected_bytes.size() - 1].end_of_string = 1'b1;
         text_mode = TEXT_MODE;
         digit_tally = 2'd0;
         escape_value = 8'h00;
      end
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_char <= ch;
      req_in_last <= last;
      predict_char(ch, last);
      chars_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_pending_text();
      foreach (pending_text[i])
         send_char(pending_text[i], i == pending_text.size() - 1);
   endtask

   task automatic send_text(input string text);
      pending_text.delete();
      for (int i = 0; i < text.len(); i++)
         pending_text.push_back(text[i]);
      send_pending_text();
   endtask

   function automatic void add_random_token();
      string known_letters = "abfrntv?\\'\"";
      string hex_chars = "0123456789abcdefABCDEF";
      string follow_chars = "0123456789abcdefxX";
      logic [7:0] ch;
      case ($urandom_range(9))
         0, 1, 2: begin
            ch = 8'($urandom_range(255));
            if (ch == BACKSLASH)
               ch = ch + 8'd1;
            pending_text.push_back(ch);
         end
         3: begin
            pending_text.push_back(BACKSLASH);
            pending_text.push_back(known_letters[$urandom_range(known_letters.len() - 1)]);
         end
         4: begin
            pending_text.push_back(BACKSLASH);
            pending_text.push_back(HEX_INTRO);
            repeat ($urandom_range(3))
               pending_text.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
         end
         5: begin
            pending_text.push_back(BACKSLASH);
            repeat ($urandom_range(1, 4))
               pending_text.push_back(ZERO_CHAR | 8'($urandom_range(7)));
         end
         6: begin
            ch = $urandom_range(1) ? "a" : "A";
            pending_text.push_back(BACKSLASH);
            pending_text.push_back(ch + 8'($urandom_range(25)));
         end
         7: begin
            pending_text.push_back(BACKSLASH);
            pending_text.push_back(8'($urandom_range(255)));
         end
         8: pending_text.push_back(follow_chars[$urandom_range(follow_chars.len() - 1)]);
         default: pending_text.push_back(BACKSLASH);
      endcase
   endfunction

   task automatic apply_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_plain_and_extremes();
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b1);
   endtask

   task automatic test_simple_escapes();
      send_text("\\t\\?\\%\\");
   endtask

   task automatic test_numeric_escapes();
      send_text("\\777\\xAf1\\xz");
   endtask

   task automatic test_string_end_cases();
      send_text("\\x");
      send_text("\\q");
   endtask

   task automatic test_random_strings(input int item_count);
      int target;
      target = chars_sent + item_count;
      while (chars_sent < target) begin
         pending_text.delete();
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8))
               pending_text.push_back($urandom_range(3) == 0 ? BACKSLASH
                                                             : 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 6)) add_random_token();
         end
         send_pending_text();
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected word: byte %02h valid %b end %b", $time,
                     rsp_out_byte, rsp_byte_valid, rsp_end_of_string);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_byte_valid !== want.byte_valid ||
                rsp_end_of_string !== want.end_of_string) begin
               $display("%0t: expected byte %02h valid %b end %b, got byte %02h valid %b end %b",
                        $time, want.out_byte, want.byte_valid, want.end_of_string,
                        rsp_out_byte, rsp_byte_valid, rsp_end_of_string);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      apply_reset();
      test_plain_and_extremes();
      test_simple_escapes();
      test_numeric_escapes();
      test_string_end_cases();
      test_random_strings(630);
      send_idle_pct = 65;
      recv_idle_pct = 12;
      test_random_strings(630);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(630);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
